/* rtl/core/cda_pkg.sv */
`default_nettype none
package cda_pkg;

    localparam int MAX_CHANNELS   = 4096;
    localparam int MAX_DECIMATION = 256;

    localparam int CH_W       = $clog2(MAX_CHANNELS);
    localparam int NCH_W      = CH_W + 1;
    localparam int SPOS_W     = $clog2(MAX_DECIMATION);
    localparam int DEC_W      = SPOS_W + 1;
    localparam int SAMPLE_W   = 8;
    localparam int AVG_W      = 8;
    localparam int SUM_W      = SAMPLE_W + SPOS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = NCH_W;
    localparam int DIV_CNT_W  = $clog2(AVG_W);

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION    = CFG_IDX_W'(1);

    localparam logic [NCH_W-1:0] NCH_RESET = NCH_W'(MAX_CHANNELS);
    localparam logic [DEC_W-1:0] DEC_RESET = DEC_W'(1);

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [DEC_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [AVG_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/cda_ram.sv */
`default_nettype none
module cda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/cda_div.sv */
`default_nettype none
module cda_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cda_pkg::div_req_t req,
    output cda_pkg::div_rsp_t      rsp
);
    import cda_pkg::*;

    localparam int DSH_W = DEC_W + AVG_W - 1;

    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [DSH_W-1:0]     dsh_reg, dsh_next;
    logic [AVG_W-1:0]     quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 fits;

    // One quotient bit per cycle, most significant first. The quotient fits
    // in AVG_W bits because a block sum never reaches divisor times 256.
    assign fits = {{(DSH_W > SUM_W ? DSH_W - SUM_W : 0){1'b0}}, rem_reg} >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend;
            dsh_next  = {req.divisor, {(AVG_W-1){1'b0}}};
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - SUM_W'(dsh_reg);
            end
            quot_next = {quot_reg[AVG_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(AVG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_next |=> !busy_reg)
        else $error("divider done while still busy");
`endif

endmodule
`default_nettype wire

/* rtl/core/channel_decimation_average_core.sv */
`default_nettype none
// Per-channel boxcar decimation of an 8-bit filterbank stream in channel-fastest
// order. Each channel sum lives in a 4096 x 16 synchronous RAM that is read when
// a sample is accepted and written back on the next cycle; the next sample is
// taken only after the write-back. In the last spectrum the sum is divided by
// the decimation factor in a shift-subtract divider, and the next sample is
// taken once the quotient is loaded into a free result register. The result
// register lets the block accept further samples while a result waits. Any
// configuration write restarts the block at channel 0 of its first spectrum;
// the first spectrum of each block overwrites the sums, so the RAM needs no
// clearing after reset.
module channel_decimation_average_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [cda_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cda_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              sample_valid,
    output logic                                   sample_ready,
    input  wire logic [cda_pkg::SAMPLE_W-1:0]      sample,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic      [cda_pkg::AVG_W-1:0]         average,
    output logic      [cda_pkg::CH_W-1:0]          channel,
    output logic                                   spectrum_end
);
    import cda_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RMW  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [NCH_W-1:0]    nch_reg;
    logic [DEC_W-1:0]    dec_reg;
    logic [CH_W-1:0]     cpos_reg, cpos_next;
    logic [SPOS_W-1:0]   spos_reg, spos_next;

    logic [CH_W-1:0]     ch_reg;
    logic [SAMPLE_W-1:0] smp_reg;
    logic                first_reg, last_spec_reg, last_chan_reg;

    logic                res_valid_reg, res_valid_next;
    logic [AVG_W-1:0]    avg_reg;
    logic [CH_W-1:0]     res_ch_reg;
    logic                res_end_reg;

    logic [NCH_W-1:0]    nch_eff;
    logic [DEC_W-1:0]    dec_eff;
    logic [CH_W-1:0]     ch_cur;
    logic                last_chan, last_spec;
    logic                accept;
    logic                out_free;
    logic                out_load;
    logic [SUM_W-1:0]    ram_rdata;
    logic [SUM_W-1:0]    sum;
    logic                ram_we;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    always_comb
    begin
        priority if (nch_reg == '0)
            nch_eff = NCH_W'(1);
        else if (nch_reg > NCH_W'(MAX_CHANNELS))
            nch_eff = NCH_W'(MAX_CHANNELS);
        else
            nch_eff = nch_reg;
        priority if (dec_reg == '0)
            dec_eff = DEC_W'(1);
        else if (dec_reg > DEC_W'(MAX_DECIMATION))
            dec_eff = DEC_W'(MAX_DECIMATION);
        else
            dec_eff = dec_reg;
    end

    assign ch_cur    = ({1'b0, cpos_reg} >= nch_eff) ? CH_W'(nch_eff - NCH_W'(1)) : cpos_reg;
    assign last_chan = ({1'b0, ch_cur} + NCH_W'(1)) >= nch_eff;
    assign last_spec = ({1'b0, spos_reg} + DEC_W'(1)) >= dec_eff;

    assign sample_ready = (state_reg == S_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign out_free     = !res_valid_reg || result_ready;

    cda_ram #(
        .WIDTH(SUM_W),
        .DEPTH(MAX_CHANNELS)
    ) u_sums (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ch_reg),
        .wdata(sum),
        .re   (accept),
        .raddr(ch_cur),
        .rdata(ram_rdata)
    );

    assign sum    = first_reg ? SUM_W'(smp_reg) : ram_rdata + SUM_W'(smp_reg);
    assign ram_we = (state_reg == S_RMW);

    assign div_req.start    = ram_we && last_spec_reg;
    assign div_req.dividend = sum;
    assign div_req.divisor  = dec_eff;

    cda_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_RMW;
            end
            S_RMW:
            begin
                state_next = last_spec_reg ? S_DIV : S_IDLE;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cpos_next = cpos_reg;
        spos_next = spos_reg;
        if (cfg_write)
        begin
            cpos_next = '0;
            spos_next = '0;
        end
        else if (accept)
        begin
            if (last_chan)
            begin
                cpos_next = '0;
                spos_next = last_spec ? '0 : spos_reg + SPOS_W'(1);
            end
            else
            begin
                cpos_next = ch_cur + CH_W'(1);
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_load)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nch_reg       <= NCH_RESET;
            dec_reg       <= DEC_RESET;
            cpos_reg      <= '0;
            spos_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cpos_reg      <= cpos_next;
            spos_reg      <= spos_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write && cfg_index == REG_CHANNEL_COUNT)
                nch_reg <= cfg_data[NCH_W-1:0];
            if (cfg_write && cfg_index == REG_DECIMATION)
                dec_reg <= cfg_data[DEC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg        <= ch_cur;
            smp_reg       <= sample;
            first_reg     <= (spos_reg == '0);
            last_spec_reg <= last_spec;
            last_chan_reg <= last_chan;
        end
        if (out_load)
        begin
            avg_reg     <= div_rsp.quotient;
            res_ch_reg  <= ch_reg;
            res_end_reg <= last_chan_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign average      = avg_reg;
    assign channel      = res_ch_reg;
    assign spectrum_end = res_end_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!res_valid_reg || result_ready))
        else $error("pending result overwritten");
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("quotient finished outside the divide state");
    a_write_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ram_we)
        else $error("sum not written back after transaction");
    a_div_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> (state_reg == S_DIV))
        else $error("divider started without waiting for the quotient");
`endif

endmodule
`default_nettype wire
